### src/tssla_pkg.sv
package tssla_pkg;

    localparam int MAX_LEDS = 256;

    localparam int TICK_W  = 24;
    localparam int DQ_W    = TICK_W + 1;
    localparam int STEP_W  = 5;
    localparam int COUNT_W = 9;
    localparam int CFG_W   = 24;
    localparam int INDEX_W = 3;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_QUERY   = 2'd1;
    localparam logic [1:0] ACT_ENABLE  = 2'd2;
    localparam logic [1:0] ACT_DISABLE = 2'd3;

    localparam logic [INDEX_W-1:0] REG_DURATION = 3'd0;
    localparam logic [INDEX_W-1:0] REG_EASE_IN  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_BLACK    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_COUNT    = 3'd3;
    localparam logic [INDEX_W-1:0] REG_REVERSE  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_RED      = 3'd5;
    localparam logic [INDEX_W-1:0] REG_GREEN    = 3'd6;
    localparam logic [INDEX_W-1:0] REG_BLUE     = 3'd7;

    localparam logic [TICK_W-1:0]  RST_DURATION = 24'd1000;
    localparam logic [TICK_W-1:0]  RST_EASE_IN  = 24'd400;
    localparam logic [TICK_W-1:0]  RST_BLACK    = 24'd200;
    localparam logic [COUNT_W-1:0] RST_COUNT    = 9'd8;
    localparam logic [7:0]         RST_RED      = 8'd255;
    localparam logic [7:0]         RST_GREEN    = 8'd160;
    localparam logic [7:0]         RST_BLUE     = 8'd0;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] elapsed_ticks;
        logic [7:0]  led_position;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [TICK_W-1:0] divisor;
        logic [TICK_W-1:0] rem_init;
        logic [DQ_W-1:0]   dq_init;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] rem;
        logic [DQ_W-1:0]   dq;
    } div_rsp_t;

endpackage

### src/tssla_divider.sv
module tssla_divider
    import tssla_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [DQ_W-1:0]   dq_reg, dq_next;
    logic [TICK_W-1:0] div_reg, div_next;
    logic [DQ_W:0]     trial;

    // one restoring step: shift the next dividend bit in, subtract if it fits
    assign trial = {1'b0, rem_reg, dq_reg[DQ_W-1]} - {2'b00, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            dq_next   = req.dq_init;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                if (trial[DQ_W])
                begin
                    rem_next = {rem_reg[TICK_W-2:0], dq_reg[DQ_W-1]};
                    dq_next  = {dq_reg[DQ_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = trial[TICK_W-1:0];
                    dq_next  = {dq_reg[DQ_W-2:0], 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        div_reg <= div_next;
    end

    assign rsp.done = busy_reg && (cnt_reg == '0);
    assign rsp.rem  = rem_reg;
    assign rsp.dq   = dq_reg;

endmodule

### src/turn_signal_sweep_led_animator.sv
// Turn-signal sweep animator. Beats on the input channel tick the animation
// clock, enable/restart it, disable it, or ask for the colour of one LED; only
// a query returns a beat. Enable, disable and a tick while disabled are handled
// in the idle state alone. A tick while enabled wraps the animation time in
// 25 steps through the shared restoring divider. A query in the dark phase
// goes straight to the output state; otherwise it makes two divider passes of
// FRACTION_BITS+1 steps each (LED displacement, phase progress) and then five
// products through the one multiplier (cube easing, then red, green, blue).
// The result sits in an output register, so the next beat is taken while it
// waits.
module turn_signal_sweep_led_animator
    import tssla_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data,
    input  logic               cfg_we,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int F  = FRACTION_BITS;
    localparam int PW = 2 * F + 2;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(F + 1);
    localparam logic [STEP_W-1:0] TICK_STEPS = STEP_W'(DQ_W);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_TICK   = 4'd1;
    localparam logic [3:0] ST_DIV_D  = 4'd2;
    localparam logic [3:0] ST_DIV_P  = 4'd3;
    localparam logic [3:0] ST_EASE   = 4'd4;
    localparam logic [3:0] ST_MUL_SQ = 4'd5;
    localparam logic [3:0] ST_MUL_CU = 4'd6;
    localparam logic [3:0] ST_EASE_E = 4'd7;
    localparam logic [3:0] ST_MUL_R  = 4'd8;
    localparam logic [3:0] ST_MUL_G  = 4'd9;
    localparam logic [3:0] ST_MUL_B  = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    localparam logic [1:0] MODE_BLACK = 2'd0;
    localparam logic [1:0] MODE_IN    = 2'd1;
    localparam logic [1:0] MODE_OUT   = 2'd2;

    logic [TICK_W-1:0]  duration_reg, ease_in_reg, black_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               reverse_reg;
    logic [7:0]         red_cfg_reg, green_cfg_reg, blue_cfg_reg;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic [TICK_W-1:0] anim_reg, anim_next;
    logic              enabled_reg, enabled_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;
    logic [F:0]        d_reg, d_next;
    logic [F:0]        p_reg, p_next;
    logic [F:0]        u_reg, u_next;
    logic [F:0]        e_reg, e_next;
    logic [7:0]        red_reg, red_next;
    logic [7:0]        green_reg, green_next;
    logic [PW-1:0]     prod_reg;

    logic              mul_en;
    logic [F:0]        mul_a, mul_b;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [TICK_W-1:0]  dur_c, ein_c;
    logic [COUNT_W-1:0] count_c, count_m1;
    logic [7:0]         pos_sat, pos_eff;
    logic [TICK_W+1:0]  dark_start, out_div;
    logic [1:0]         mode_q;
    logic [TICK_W-1:0]  p_num, p_div;
    logic [F+2:0]       sum2;
    logic [F+2:0]       tdiff;
    logic [F:0]         tc;
    logic [7:0]         scaled;
    logic               in_fire;

    tssla_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    function automatic logic [7:0] chan_val(input logic [1:0] mode,
                                            input logic [7:0] c,
                                            input logic [7:0] s);
        logic [7:0] r;
        begin
            case (mode)
                MODE_IN:  r = s;
                MODE_OUT: r = c - s;
                default:  r = 8'd0;
            endcase
            return r;
        end
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign dur_c = (duration_reg == '0) ? TICK_W'(1) : duration_reg;
    assign ein_c = (ease_in_reg == '0) ? TICK_W'(1) : ease_in_reg;

    always_comb
    begin
        if (count_reg < COUNT_W'(2))
            count_c = COUNT_W'(2);
        else if (count_reg > COUNT_W'(MAX_LEDS))
            count_c = COUNT_W'(MAX_LEDS);
        else
            count_c = count_reg;
    end

    assign count_m1 = count_c - 1'b1;
    assign pos_sat  = ({1'b0, in_data.led_position} > count_m1) ? count_m1[7:0]
                                                               : in_data.led_position;
    assign pos_eff  = reverse_reg ? (count_m1[7:0] - pos_sat) : pos_sat;

    assign dark_start = {2'b00, duration_reg} - {2'b00, black_reg};
    assign out_div    = dark_start - {2'b00, ease_in_reg};

    always_comb
    begin
        if (anim_reg <= ease_in_reg)
            mode_q = MODE_IN;
        else if ($signed({2'b00, anim_reg}) <= $signed(dark_start))
            mode_q = MODE_OUT;
        else
            mode_q = MODE_BLACK;
    end

    assign p_num = (mode_reg == MODE_IN) ? anim_reg : (anim_reg - ease_in_reg);
    assign p_div = (mode_reg == MODE_IN) ? ein_c : out_div[TICK_W-1:0];

    // displaced phase 2p + d - 1, clamped to 0..1
    assign sum2  = {1'b0, p_reg, 1'b0} + {2'b00, d_reg};
    assign tdiff = sum2 - {2'b00, ONE};
    always_comb
    begin
        if (sum2 < {2'b00, ONE})
            tc = '0;
        else if (tdiff > {2'b00, ONE})
            tc = ONE;
        else
            tc = tdiff[F:0];
    end

    assign scaled = prod_reg[F+7:F];

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        anim_next      = anim_reg;
        enabled_next   = enabled_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        u_next         = u_reg;
        e_next         = e_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        mul_en         = 1'b0;
        mul_a          = u_reg;
        mul_b          = u_reg;
        div_req        = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_data.action)
                        ACT_TICK:
                        begin
                            if (enabled_reg)
                            begin
                                div_req.start    = 1'b1;
                                div_req.steps    = TICK_STEPS;
                                div_req.divisor  = dur_c;
                                div_req.rem_init = '0;
                                div_req.dq_init  = {1'b0, anim_reg}
                                                 + {9'd0, in_data.elapsed_ticks};
                                state_next = ST_TICK;
                            end
                        end
                        ACT_QUERY:
                        begin
                            mode_next = mode_q;
                            if (mode_q == MODE_BLACK)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.steps    = FRAC_STEPS;
                                div_req.divisor  = {{(TICK_W-COUNT_W){1'b0}}, count_m1};
                                div_req.rem_init = {{(TICK_W-7){1'b0}}, pos_eff[7:1]};
                                div_req.dq_init  = {pos_eff[0], {(DQ_W-1){1'b0}}};
                                state_next = ST_DIV_D;
                            end
                        end
                        ACT_ENABLE:
                        begin
                            anim_next    = '0;
                            enabled_next = 1'b1;
                        end
                        ACT_DISABLE:
                        begin
                            enabled_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (div_rsp.done)
                begin
                    anim_next  = div_rsp.rem;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_D:
            begin
                if (div_rsp.done)
                begin
                    d_next           = div_rsp.dq[F:0];
                    div_req.start    = 1'b1;
                    div_req.steps    = FRAC_STEPS;
                    div_req.divisor  = p_div;
                    div_req.rem_init = {1'b0, p_num[TICK_W-1:1]};
                    div_req.dq_init  = {p_num[0], {(DQ_W-1){1'b0}}};
                    state_next       = ST_DIV_P;
                end
            end
            ST_DIV_P:
            begin
                if (div_rsp.done)
                begin
                    p_next     = div_rsp.dq[F:0];
                    state_next = ST_EASE;
                end
            end
            ST_EASE:
            begin
                u_next     = ONE - tc;
                state_next = ST_MUL_SQ;
            end
            ST_MUL_SQ:
            begin
                mul_en     = 1'b1;
                state_next = ST_MUL_CU;
            end
            ST_MUL_CU:
            begin
                mul_en     = 1'b1;
                mul_a      = prod_reg[2*F:F];
                state_next = ST_EASE_E;
            end
            ST_EASE_E:
            begin
                e_next     = ONE - prod_reg[2*F:F];
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                mul_en     = 1'b1;
                mul_a      = {{(F-7){1'b0}}, red_cfg_reg};
                mul_b      = e_reg;
                state_next = ST_MUL_G;
            end
            ST_MUL_G:
            begin
                red_next   = chan_val(mode_reg, red_cfg_reg, scaled);
                mul_en     = 1'b1;
                mul_a      = {{(F-7){1'b0}}, green_cfg_reg};
                mul_b      = e_reg;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                green_next = chan_val(mode_reg, green_cfg_reg, scaled);
                mul_en     = 1'b1;
                mul_a      = {{(F-7){1'b0}}, blue_cfg_reg};
                mul_b      = e_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_BLACK)
                    begin
                        out_data_next = '0;
                    end
                    else
                    begin
                        out_data_next.out_red   = red_reg;
                        out_data_next.out_green = green_reg;
                        out_data_next.out_blue  = chan_val(mode_reg, blue_cfg_reg, scaled);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg  <= RST_DURATION;
            ease_in_reg   <= RST_EASE_IN;
            black_reg     <= RST_BLACK;
            count_reg     <= RST_COUNT;
            reverse_reg   <= 1'b0;
            red_cfg_reg   <= RST_RED;
            green_cfg_reg <= RST_GREEN;
            blue_cfg_reg  <= RST_BLUE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DURATION: duration_reg  <= cfg_data[TICK_W-1:0];
                REG_EASE_IN:  ease_in_reg   <= cfg_data[TICK_W-1:0];
                REG_BLACK:    black_reg     <= cfg_data[TICK_W-1:0];
                REG_COUNT:    count_reg     <= cfg_data[COUNT_W-1:0];
                REG_REVERSE:  reverse_reg   <= cfg_data[0];
                REG_RED:      red_cfg_reg   <= cfg_data[7:0];
                REG_GREEN:    green_cfg_reg <= cfg_data[7:0];
                REG_BLUE:     blue_cfg_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_BLACK;
            anim_reg      <= '0;
            enabled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            anim_reg      <= anim_next;
            enabled_reg   <= enabled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        d_reg        <= d_next;
        p_reg        <= p_next;
        u_reg        <= u_next;
        e_reg        <= e_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

endmodule

### src/tssla_checker.sv
module tssla_checker
    import tssla_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a waiting result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

    // a query occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.action == ACT_QUERY) |=> !in_ready)
    else $error("input ready straight after a query");

    // a new result only comes out of a busy block
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

    // tick, enable and disable never give a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.action != ACT_QUERY) && !out_valid
        |=> !out_valid)
    else $error("result from a non-query beat");

endmodule

bind turn_signal_sweep_led_animator tssla_checker u_tssla_checker (.*);

### test/tb.sv
module tb;
    import tssla_pkg::*;

    localparam int     FRAC        = 16;
    localparam longint ONE         = longint'(1) << FRAC;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     SETTLE      = 64;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic               cfg_we    = 1'b0;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    turn_signal_sweep_led_animator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // animator state as the testbench sees it
    logic [TICK_W-1:0]  m_duration;
    logic [TICK_W-1:0]  m_ease_in;
    logic [TICK_W-1:0]  m_black;
    logic [COUNT_W-1:0] m_count;
    logic               m_reverse;
    logic [7:0]         m_red;
    logic [7:0]         m_green;
    logic [7:0]         m_blue;
    logic [TICK_W-1:0]  m_anim;
    logic               m_enabled;

    out_item_t colour_q[$];

    int snd_idle        = 0;
    int rcv_idle        = 0;
    int stall_left      = 0;
    int cycles          = 0;
    int errors          = 0;
    int beats_in        = 0;
    int colours_checked = 0;
    int reg_writes      = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [7:0] fade(logic [7:0] c, longint e, bit rising);
        longint part;
        longint lvl;
        part = (longint'(c) * e) >> FRAC;
        lvl  = rising ? part : longint'(c) - part;
        return lvl[7:0];
    endfunction

    function automatic out_item_t led_colour(logic [7:0] pos_in);
        longint    cnt;
        longint    pos;
        longint    d;
        longint    p;
        longint    t;
        longint    u;
        longint    u3;
        longint    e;
        longint    outdiv;
        bit        rising;
        out_item_t r;
        cnt = m_count;
        if (cnt < 2)
            cnt = 2;
        if (cnt > MAX_LEDS)
            cnt = MAX_LEDS;
        pos = pos_in;
        if (pos > cnt - 1)
            pos = cnt - 1;
        if (m_reverse)
            pos = cnt - 1 - pos;
        d = (pos * ONE) / (cnt - 1);
        if (m_anim <= m_ease_in)
        begin
            rising = 1'b1;
            p = (longint'(m_anim) * ONE) / ((m_ease_in != 0) ? longint'(m_ease_in) : 1);
        end
        else if (longint'(m_anim) <= longint'(m_duration) - longint'(m_black))
        begin
            rising = 1'b0;
            outdiv = longint'(m_duration) - longint'(m_ease_in) - longint'(m_black);
            if (outdiv < 1)
                outdiv = 1;
            p = ((longint'(m_anim) - longint'(m_ease_in)) * ONE) / outdiv;
        end
        else
        begin
            return '0;
        end
        t = 2 * p + d - ONE;
        if (t < 0)
            t = 0;
        if (t > ONE)
            t = ONE;
        u  = ONE - t;
        u3 = (((u * u) >> FRAC) * u) >> FRAC;
        e  = ONE - u3;
        r.out_red   = fade(m_red, e, rising);
        r.out_green = fade(m_green, e, rising);
        r.out_blue  = fade(m_blue, e, rising);
        return r;
    endfunction

    task automatic apply_beat(in_item_t it);
        longint span;
        case (it.action)
            ACT_TICK:
            begin
                if (m_enabled)
                begin
                    span = (m_duration != 0) ? longint'(m_duration) : 1;
                    m_anim = TICK_W'((longint'(m_anim) + longint'(it.elapsed_ticks)) % span);
                end
            end
            ACT_QUERY:
                colour_q.push_back(led_colour(it.led_position));
            ACT_ENABLE:
            begin
                m_anim    = '0;
                m_enabled = 1'b1;
            end
            default:
                m_enabled = 1'b0;
        endcase
    endtask

    task automatic send_beat(logic [1:0] act, logic [15:0] elapsed, logic [7:0] pos);
        in_item_t it;
        it.action        = act;
        it.elapsed_ticks = elapsed;
        it.led_position  = pos;
        if ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < snd_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_beat(it);
        beats_in++;
    endtask

    // input side goes quiet until every colour is back, then lets a tick finish
    task automatic wait_for_colours();
        in_valid <= 1'b0;
        @(posedge clk);
        while (colour_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_DURATION: m_duration = val;
            REG_EASE_IN:  m_ease_in  = val;
            REG_BLACK:    m_black    = val;
            REG_COUNT:    m_count    = val[COUNT_W-1:0];
            REG_REVERSE:  m_reverse  = val[0];
            REG_RED:      m_red      = val[7:0];
            REG_GREEN:    m_green    = val[7:0];
            default:      m_blue     = val[7:0];
        endcase
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [23:0] dur, logic [23:0] ein, logic [23:0] blk,
                              logic [8:0] cnt, logic rev,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        write_reg(REG_DURATION, dur);
        write_reg(REG_EASE_IN, ein);
        write_reg(REG_BLACK, blk);
        write_reg(REG_COUNT, CFG_W'(cnt));
        write_reg(REG_REVERSE, CFG_W'(rev));
        write_reg(REG_RED, CFG_W'(r));
        write_reg(REG_GREEN, CFG_W'(g));
        write_reg(REG_BLUE, CFG_W'(b));
    endtask

    // output side: random or forced stalls, and the colour check
    initial
    begin
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (colour_q.size() == 0)
                begin
                    $error("colour beat with no query waiting: %h", out_data);
                    errors++;
                end
                else
                begin
                    want = colour_q.pop_front();
                    colours_checked++;
                    if (out_data.out_red !== want.out_red)
                    begin
                        $error("out_red: expected %0d, got %0d", want.out_red, out_data.out_red);
                        errors++;
                    end
                    if (out_data.out_green !== want.out_green)
                    begin
                        $error("out_green: expected %0d, got %0d",
                               want.out_green, out_data.out_green);
                        errors++;
                    end
                    if (out_data.out_blue !== want.out_blue)
                    begin
                        $error("out_blue: expected %0d, got %0d",
                               want.out_blue, out_data.out_blue);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    task automatic test_reset_state();
        send_beat(ACT_QUERY, 16'd0, 8'd0);
        send_beat(ACT_TICK, 16'd100, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd255);
        send_beat(ACT_ENABLE, 16'd0, 8'd0);
        send_beat(ACT_TICK, 16'hFFFF, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd3);
        send_beat(ACT_TICK, 16'd300, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd5);
        send_beat(ACT_DISABLE, 16'd0, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd7);
    endtask

    task automatic test_special_cases();
        // zero duration, zero ease-in, zero count
        wait_for_colours();
        set_config(24'd0, 24'd0, 24'd0, 9'd0, 1'b1, 8'd255, 8'd255, 8'd255);
        send_beat(ACT_ENABLE, 16'd0, 8'd0);
        send_beat(ACT_TICK, 16'hFFFF, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd255);
        // no room for ease-out, count above range
        wait_for_colours();
        set_config(24'd100, 24'd50, 24'd60, 9'd511, 1'b0, 8'd128, 8'd1, 8'd255);
        send_beat(ACT_ENABLE, 16'd0, 8'd0);
        send_beat(ACT_TICK, 16'd45, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd10);
        send_beat(ACT_QUERY, 16'd0, 8'd255);
        // durations and LED count at full scale
        wait_for_colours();
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 9'd256, 1'b1, 8'd255, 8'd0, 8'd255);
        send_beat(ACT_ENABLE, 16'd0, 8'd0);
        send_beat(ACT_TICK, 16'hFFFF, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd128);
        // time left beyond a shortened duration, then wrapped by a tick
        wait_for_colours();
        set_config(24'hFFFFFF, 24'd1, 24'd0, 9'd2, 1'b0, 8'd200, 8'd100, 8'd50);
        send_beat(ACT_ENABLE, 16'd0, 8'd0);
        send_beat(ACT_TICK, 16'hFFFF, 8'd0);
        send_beat(ACT_TICK, 16'hFFFF, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd1);
        wait_for_colours();
        write_reg(REG_DURATION, 24'd1000);
        send_beat(ACT_QUERY, 16'd0, 8'd0);
        send_beat(ACT_TICK, 16'd1, 8'd0);
        send_beat(ACT_QUERY, 16'd0, 8'd1);
    endtask

    task automatic test_backpressure();
        int i;
        wait_for_colours();
        set_config(24'd1000, 24'd400, 24'd200, 9'd8, 1'b0, 8'd255, 8'd160, 8'd0);
        snd_idle = 0;
        rcv_idle = 0;
        send_beat(ACT_ENABLE, 16'd0, 8'd0);
        stall_left = 800;
        for (i = 0; i < 40; i++)
        begin
            if (i % 4 == 0)
                send_beat(ACT_TICK, 16'($urandom_range(0, 200)), 8'd0);
            else
                send_beat(ACT_QUERY, 16'd0, 8'($urandom_range(0, 9)));
        end
        wait_for_colours();
        stall_left = 300;
        for (i = 0; i < 20; i++)
            send_beat(ACT_QUERY, 16'd0, 8'($urandom));
        wait_for_colours();
    endtask

    task automatic random_config();
        int unsigned dur;
        int unsigned ein;
        int unsigned blk;
        int unsigned cnt;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            dur = $urandom_range(3, 3000);
        else if (sel == 7)
            dur = 24'hFFFFFF;
        else if (sel == 8)
            dur = $urandom & 24'hFFFFFF;
        else
            dur = $urandom_range(0, 1);
        if (dur >= 3 && $urandom_range(0, 4) != 0)
        begin
            ein = $urandom_range(1, dur - 2);
            blk = $urandom_range(0, dur - ein - 1);
        end
        else
        begin
            ein = $urandom & 24'hFFFFFF;
            blk = ($urandom_range(0, 1) != 0) ? ($urandom & 24'hFFFFFF) : 0;
        end
        if ($urandom_range(0, 3) != 0)
            cnt = $urandom_range(2, 256);
        else
            cnt = $urandom & 9'h1FF;
        set_config(24'(dur), 24'(ein), 24'(blk), 9'(cnt), 1'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic random_beats(int n);
        int          i;
        int unsigned sel;
        longint      lim;
        longint      cnt;
        logic [15:0] elapsed;
        logic [7:0]  pos;
        i = 0;
        send_beat(ACT_ENABLE, 16'd0, 8'd0);
        while (i < n)
        begin
            sel = $urandom_range(0, 99);
            lim = (m_duration != 0) ? longint'(m_duration) / 6 + 1 : 1;
            if (lim > 65535)
                lim = 65535;
            if ($urandom_range(0, 9) == 0)
                elapsed = 16'($urandom);
            else
                elapsed = 16'($urandom_range(0, int'(lim)));
            cnt = (m_count < 2) ? 2 : ((m_count > MAX_LEDS) ? MAX_LEDS : m_count);
            if ($urandom_range(0, 4) == 0)
                pos = 8'($urandom);
            else
                pos = 8'($urandom_range(0, int'(cnt) - 1));
            if (!m_enabled && sel < 70)
                send_beat(ACT_ENABLE, elapsed, pos);
            else if (sel < 45)
                send_beat(ACT_TICK, elapsed, pos);
            else if (sel < 90)
                send_beat(ACT_QUERY, elapsed, pos);
            else if (sel < 95)
                send_beat(ACT_ENABLE, elapsed, pos);
            else
                send_beat(ACT_DISABLE, elapsed, pos);
            if (!(sel < 45 && !m_enabled))
                i++;
        end
    endtask

    task automatic test_random_traffic();
        int mix;
        int blk;
        for (mix = 0; mix < 3; mix++)
        begin
            snd_idle = (mix == 0) ? 8 : ((mix == 1) ? 82 : 0);
            rcv_idle = (mix == 0) ? 82 : ((mix == 1) ? 8 : 0);
            for (blk = 0; blk < 6; blk++)
            begin
                wait_for_colours();
                random_config();
                random_beats(92);
            end
        end
    endtask

    initial
    begin
        m_duration = RST_DURATION;
        m_ease_in  = RST_EASE_IN;
        m_black    = RST_BLACK;
        m_count    = RST_COUNT;
        m_reverse  = 1'b0;
        m_red      = RST_RED;
        m_green    = RST_GREEN;
        m_blue     = RST_BLUE;
        m_anim     = '0;
        m_enabled  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_special_cases();
        test_backpressure();
        test_random_traffic();
        wait_for_colours();

        $display("Run covered %0d input beats, %0d colour beats checked, %0d register writes,",
                 beats_in, colours_checked, reg_writes);
        $display("idle mixes 8/82, 82/8 and none, plus long output stalls.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
